// File: hdl/cdc_pkg.sv
// Package for the compass direction converter: angle formats, turn constants and the
// CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps

package cdc_pkg;

	localparam int DIR_W      = 16;
	localparam int ANGLE_W    = 32;
	localparam int GUARD_BITS = 16;
	localparam int ATAN_DEPTH = 32;

	localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [ANGLE_W-1:0] ROUND_HALF   = 32'd32768;
	localparam logic [DIR_W-1:0]   QUARTER_TURN = 16'd16384;
	localparam logic [DIR_W-1:0]   HALF_TURN16  = 16'd32768;
	localparam logic [DIR_W-1:0]   NORTH        = 16'd0;

	// atan(2^-i), 2^32 units per turn
	localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

endpackage

// File: hdl/cdc_if.sv
// Stream interfaces of the compass direction converter: vector samples in, bearings out.
// Depends on cdc_pkg.
`timescale 1ns / 1ps

interface cdc_in_if #(
	parameter int DATA_WIDTH = 16
) ();
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic signed [DATA_WIDTH-1:0] first_value;
	logic signed [DATA_WIDTH-1:0] second_value;

	modport source (output valid, output mode, output first_value, output second_value,
		input ready);
	modport sink (input valid, input mode, input first_value, input second_value,
		output ready);
endinterface

interface cdc_out_if #(
	parameter int DATA_WIDTH = 16
) ();
	logic                        valid;
	logic                        ready;
	logic [cdc_pkg::DIR_W-1:0]   direction;
	logic [DATA_WIDTH-1:0]       magnitude;

	modport source (output valid, output direction, output magnitude, input ready);
	modport sink (input valid, input direction, input magnitude, output ready);
endinterface

// File: hdl/compass_direction_converter.sv
// Compass direction converter top level: input conditioning, pipelined CORDIC vectoring
// stages and bearing output register. Depends on cdc_pkg and cdc_if.
//
//   channel   modport           transfer content
//   sample    cdc_in_if.sink    mode, first_value (x or magnitude), second_value (y or angle)
//   bearing   cdc_out_if.source direction (0 = North, clockwise), magnitude
//
// One sample per cycle sustained while bearing.ready is high; one conditioning
// stage, one stage per CORDIC iteration, one rounding/output stage.
// Reset clears only the stage valid bits.
// A stage holds while the next one is full and stalled; empty stages ahead still fill,
// so bubbles are squeezed out and sample.ready drops only when every stage is full.
`timescale 1ns / 1ps

module compass_direction_converter #(
	parameter int DATA_WIDTH        = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	cdc_in_if.sink      sample,
	cdc_out_if.source   bearing
);

	localparam int N  = CORDIC_ITERATIONS;
	localparam int DW = DATA_WIDTH;
	localparam int W  = DW + cdc_pkg::GUARD_BITS + 2;
	localparam int AW = cdc_pkg::ANGLE_W;
	localparam int RW = cdc_pkg::DIR_W;

	// stage index 0 is conditioning, k+1 holds the result of iteration k
	logic [N:0]            v_sk;
	logic signed [W-1:0]   x_sk    [N+1];
	logic signed [W-1:0]   y_sk    [N+1];
	logic [AW-1:0]         z_sk    [N+1];
	logic [N:0]            byp_sk;
	logic [RW-1:0]         bdir_sk [N+1];
	logic [DW-1:0]         mag_sk  [N+1];

	logic                  v_sf;
	logic [RW-1:0]         direction_sf;
	logic [DW-1:0]         magnitude_sf;

	logic [N+1:0]          rdy;

	// ready chain
	assign rdy[N+1] = !v_sf || bearing.ready;
	for (genvar k = 0; k <= N; k++) begin : g_rdy
		assign rdy[k] = !v_sk[k] || rdy[k+1];
	end

	assign sample.ready = rdy[0];

	// conditioning
	logic signed [W-1:0]   xa, ya, x0, y0;
	logic [AW-1:0]         z0;
	logic [DW+RW-1:0]      ang_ext;
	logic [RW-1:0]         ang;
	logic [DW-1:0]         abs_mag;
	logic                  null_vec;

	always_comb begin
		xa = {{(W-DW-cdc_pkg::GUARD_BITS){sample.first_value[DW-1]}}, sample.first_value,
			{cdc_pkg::GUARD_BITS{1'b0}}};
		ya = {{(W-DW-cdc_pkg::GUARD_BITS){sample.second_value[DW-1]}}, sample.second_value,
			{cdc_pkg::GUARD_BITS{1'b0}}};
		if (xa[W-1]) begin
			x0 = -xa;
			y0 = -ya;
			z0 = cdc_pkg::HALF_TURN;
		end else begin
			x0 = xa;
			y0 = ya;
			z0 = '0;
		end
		ang_ext  = {{RW{1'b0}}, sample.second_value};
		ang      = ang_ext[RW-1:0];
		abs_mag  = sample.first_value[DW-1] ? (~sample.first_value + 1'b1)
			: sample.first_value;
		if (sample.first_value[DW-1]) begin
			ang = ang + cdc_pkg::HALF_TURN16;
		end
		null_vec = (sample.first_value == '0) && (sample.second_value == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_sk[0] <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			x_sk[0]    <= x0;
			y_sk[0]    <= y0;
			z_sk[0]    <= z0;
			byp_sk[0]  <= sample.mode || null_vec;
			bdir_sk[0] <= sample.mode ? ang : cdc_pkg::NORTH;
			mag_sk[0]  <= sample.mode ? abs_mag : '0;
		end
	end

	// CORDIC vectoring iterations, one per stage
	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [W-1:0] xs, ys, xn, yn;
		logic [AW-1:0]       zn;

		always_comb begin
			xs = x_sk[i] >>> i;
			ys = y_sk[i] >>> i;
			if (!y_sk[i][W-1]) begin
				xn = x_sk[i] + ys;
				yn = y_sk[i] - xs;
				zn = z_sk[i] + cdc_pkg::ATAN_TAB[i];
			end else begin
				xn = x_sk[i] - ys;
				yn = y_sk[i] + xs;
				zn = z_sk[i] - cdc_pkg::ATAN_TAB[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[i+1] <= 1'b0;
			end else if (rdy[i+1]) begin
				v_sk[i+1] <= v_sk[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i+1]) begin
				x_sk[i+1]    <= xn;
				y_sk[i+1]    <= yn;
				z_sk[i+1]    <= zn;
				byp_sk[i+1]  <= byp_sk[i];
				bdir_sk[i+1] <= bdir_sk[i];
				mag_sk[i+1]  <= mag_sk[i];
			end
		end
	end

	// rounding and bearing
	logic [AW-1:0] z_rnd;
	logic [RW-1:0] dir_calc;

	always_comb begin
		z_rnd    = z_sk[N] + cdc_pkg::ROUND_HALF;
		dir_calc = cdc_pkg::QUARTER_TURN - z_rnd[AW-1:AW-RW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (rdy[N+1]) begin
			v_sf <= v_sk[N];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[N+1]) begin
			direction_sf <= byp_sk[N] ? bdir_sk[N] : dir_calc;
			magnitude_sf <= mag_sk[N];
		end
	end

	assign bearing.valid     = v_sf;
	assign bearing.direction = direction_sf;
	assign bearing.magnitude = magnitude_sf;

endmodule

// File: dv/tb.sv
// Testbench for compass_direction_converter: directed table then random vectors,
// checked against a CORDIC bearing predictor. Depends on cdc_pkg, cdc_if and the top level.
`timescale 1ns / 1ps

module tb;

	localparam int DW           = 16;
	localparam int CORDIC_ITERS = 16;
	localparam int RANDOM_ITEMS = 830;
	localparam int NUM_DIRECTED = 23;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum logic {
		MODE_CARTESIAN = 1'b0,
		MODE_POLAR     = 1'b1
	} mode_t;

	typedef struct packed {
		logic [cdc_pkg::DIR_W-1:0] direction;
		logic [DW-1:0]             magnitude;
	} bearing_t;

	typedef struct {
		mode_t                mode;
		logic signed [DW-1:0] first;
		logic signed [DW-1:0] second;
		bearing_t             bearing;
	} pending_t;

	typedef struct {
		mode_t mode;
		int    first;
		int    second;
		bit    known;
		int    exp_dir;
		int    exp_mag;
	} vector_row_t;

	// typed expectations only for null vectors and polar rows
	vector_row_t directed_rows [NUM_DIRECTED] = '{
		'{MODE_CARTESIAN, 0, 0, 1'b1, 0, 0},
		'{MODE_POLAR, 0, 0, 1'b1, 0, 0},
		'{MODE_POLAR, 0, 1234, 1'b1, 1234, 0},
		'{MODE_POLAR, 32767, -1, 1'b1, 65535, 32767},
		'{MODE_POLAR, -32768, 0, 1'b1, 32768, 32768},
		'{MODE_POLAR, -1, -32768, 1'b1, 0, 1},
		'{MODE_POLAR, 100, 32767, 1'b1, 32767, 100},
		'{MODE_POLAR, -5, 16384, 1'b1, 49152, 5},
		'{MODE_CARTESIAN, 1, 0, 1'b0, 0, 0},
		'{MODE_CARTESIAN, -1, 0, 1'b0, 0, 0},
		'{MODE_CARTESIAN, 0, 1, 1'b0, 0, 0},
		'{MODE_CARTESIAN, 0, -1, 1'b0, 0, 0},
		'{MODE_CARTESIAN, 32767, 0, 1'b0, 0, 0},
		'{MODE_CARTESIAN, -32768, 0, 1'b0, 0, 0},
		'{MODE_CARTESIAN, 0, 32767, 1'b0, 0, 0},
		'{MODE_CARTESIAN, 0, -32768, 1'b0, 0, 0},
		'{MODE_CARTESIAN, 32767, 32767, 1'b0, 0, 0},
		'{MODE_CARTESIAN, -32768, -32768, 1'b0, 0, 0},
		'{MODE_CARTESIAN, -32768, 32767, 1'b0, 0, 0},
		'{MODE_CARTESIAN, 32767, -32768, 1'b0, 0, 0},
		'{MODE_CARTESIAN, 1, -1, 1'b0, 0, 0},
		'{MODE_CARTESIAN, -1, 1, 1'b0, 0, 0},
		'{MODE_CARTESIAN, 12345, -6789, 1'b0, 0, 0}
	};

	logic clk;
	logic arst_n;

	cdc_in_if  #(.DATA_WIDTH(DW)) smp ();
	cdc_out_if #(.DATA_WIDTH(DW)) brg ();

	compass_direction_converter #(
		.DATA_WIDTH(DW),
		.CORDIC_ITERATIONS(CORDIC_ITERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(smp),
		.bearing(brg)
	);

	pending_t pending_bearings [$];
	bearing_t drv_exp;
	bit       drv_known;
	int       errors;
	int       cycles;
	int       n_cart, n_null, n_polar, n_neg_mag, n_checked;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// atan2(y, x) in 16-bit binary angle units
	function automatic logic [cdc_pkg::DIR_W-1:0] cordic_heading(logic signed [DW-1:0] xin,
		logic signed [DW-1:0] yin);
		longint                      x, y, nx, ny, xs, ys;
		logic [cdc_pkg::ANGLE_W-1:0] z;
		logic [cdc_pkg::ANGLE_W:0]   rounded;
		x = longint'(xin) * 65536;
		y = longint'(yin) * 65536;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = cdc_pkg::HALF_TURN;
		end
		for (int i = 0; i < CORDIC_ITERS && i < cdc_pkg::ATAN_DEPTH; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				nx = x + ys;
				ny = y - xs;
				z = z + cdc_pkg::ATAN_TAB[i];
			end else begin
				nx = x - ys;
				ny = y + xs;
				z = z - cdc_pkg::ATAN_TAB[i];
			end
			x = nx;
			y = ny;
		end
		rounded = {1'b0, z} + {1'b0, cdc_pkg::ROUND_HALF};
		return rounded[cdc_pkg::ANGLE_W-1:cdc_pkg::ANGLE_W-cdc_pkg::DIR_W];
	endfunction

	function automatic bearing_t predict_bearing(mode_t m, logic signed [DW-1:0] a,
		logic signed [DW-1:0] b);
		bearing_t                  res;
		logic signed [DW:0]        wide;
		logic [cdc_pkg::DIR_W-1:0] ang;
		res = '0;
		if (m == MODE_POLAR) begin
			wide = a;
			ang  = b[cdc_pkg::DIR_W-1:0];
			if (a < 0) begin
				res.magnitude = DW'(-wide);
				ang = ang + cdc_pkg::HALF_TURN16;
			end else begin
				res.magnitude = a;
			end
			res.direction = ang;
		end else if (a == 0 && b == 0) begin
			res.direction = cdc_pkg::NORTH;
		end else begin
			res.direction = cdc_pkg::QUARTER_TURN - cordic_heading(a, b);
		end
		return res;
	endfunction

	always @(posedge clk) begin
		pending_t entry;
		if (smp.valid && smp.ready) begin
			entry.mode    = mode_t'(smp.mode);
			entry.first   = smp.first_value;
			entry.second  = smp.second_value;
			entry.bearing = drv_known ? drv_exp
				: predict_bearing(entry.mode, entry.first, entry.second);
			pending_bearings.push_back(entry);
			if (entry.mode == MODE_POLAR) begin
				n_polar++;
				if (entry.first < 0)
					n_neg_mag++;
			end else begin
				n_cart++;
				if (entry.first == 0 && entry.second == 0)
					n_null++;
			end
		end
		if (brg.valid && brg.ready) begin
			if (pending_bearings.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer dir=%0d mag=%0d", $time,
					brg.direction, brg.magnitude);
			end else begin
				entry = pending_bearings.pop_front();
				n_checked++;
				if (brg.direction !== entry.bearing.direction) begin
					errors++;
					$display("%0t: direction mode=%0d in=(%0d,%0d) expected %0d actual %0d",
						$time, entry.mode, entry.first, entry.second,
						entry.bearing.direction, brg.direction);
				end
				if (brg.magnitude !== entry.bearing.magnitude) begin
					errors++;
					$display("%0t: magnitude mode=%0d in=(%0d,%0d) expected %0d actual %0d",
						$time, entry.mode, entry.first, entry.second,
						entry.bearing.magnitude, brg.magnitude);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d transfers outstanding", $time,
				pending_bearings.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	// receiver backpressure: free-running, then light, heavy and periodic stalls
	always @(negedge clk) begin
		case (cycles[9:8])
			2'd0: begin
				brg.ready <= 1'b1;
			end
			2'd1: begin
				brg.ready <= ($urandom_range(0, 9) < 7);
			end
			2'd2: begin
				brg.ready <= ($urandom_range(0, 9) < 3);
			end
			default: begin
				brg.ready <= (cycles[2:0] != 3'd0);
			end
		endcase
	end

	task automatic send_vector(mode_t m, logic signed [DW-1:0] a, logic signed [DW-1:0] b,
		bit known, bearing_t exp_b, int gap);
		if (gap > 0) begin
			@(negedge clk);
			smp.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		smp.valid        <= 1'b1;
		smp.mode         <= m;
		smp.first_value  <= a;
		smp.second_value <= b;
		drv_known        <= known;
		drv_exp          <= exp_b;
		do @(posedge clk); while (!smp.ready);
	endtask

	task automatic drain_bearings();
		@(negedge clk);
		smp.valid <= 1'b0;
		while (pending_bearings.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DW-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			default: return DW'($urandom);
		endcase
	endfunction

	task automatic pick_vector(output mode_t m, output logic signed [DW-1:0] a,
		output logic signed [DW-1:0] b);
		m = MODE_CARTESIAN;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				a = DW'($urandom);
				b = DW'($urandom);
			end
			4: begin
				a = DW'($urandom_range(0, 16)) - 16'sd8;
				b = DW'($urandom_range(0, 16)) - 16'sd8;
			end
			5: begin
				a = DW'($urandom);
				b = DW'($urandom);
				if ($urandom_range(0, 1))
					a = '0;
				else
					b = '0;
			end
			6: begin
				a = pick_extreme();
				b = pick_extreme();
			end
			default: begin
				m = MODE_POLAR;
				a = ($urandom_range(0, 7) == 0) ? pick_extreme() : DW'($urandom);
				b = DW'($urandom);
			end
		endcase
	endtask

	initial begin
		mode_t                m;
		logic signed [DW-1:0] a, b;
		bearing_t             typed;
		int                   burst_left;
		int                   gap;

		arst_n           = 1'b0;
		smp.valid        = 1'b0;
		smp.mode         = MODE_CARTESIAN;
		smp.first_value  = '0;
		smp.second_value = '0;
		brg.ready        = 1'b0;
		drv_known        = 1'b0;
		drv_exp          = '0;
		errors           = 0;
		cycles           = 0;
		burst_left       = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			typed.direction = cdc_pkg::DIR_W'(directed_rows[i].exp_dir);
			typed.magnitude = DW'(directed_rows[i].exp_mag);
			send_vector(directed_rows[i].mode, DW'(directed_rows[i].first),
				DW'(directed_rows[i].second), directed_rows[i].known, typed,
				(i % 4 == 3) ? 2 : 0);
		end
		drain_bearings();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				drain_bearings();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end else begin
				gap = 0;
			end
			burst_left--;
			pick_vector(m, a, b);
			send_vector(m, a, b, 1'b0, '0, gap);
		end
		drain_bearings();
		repeat (CORDIC_ITERS + 4) @(posedge clk);

		$display("covered %0d cartesian transfers (%0d null vectors) and %0d polar (%0d negative)",
			n_cart, n_null, n_polar, n_neg_mag);
		$display("%0d bearings checked under bursty input and varied output stalls", n_checked);
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
